// ===== hdl/mpi_pkg.sv =====
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared widths, codes and controller/datapath interface types for the
// modular power and inverse block.
// ----------------------------------------------------------------------------
package mpi_pkg;

  localparam int MOD_W    = 31;
  localparam int EXP_W    = 63;
  localparam int EXP_CNT_W = $clog2(EXP_W + 1);
  localparam int MM_CNT_W = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WAIT,
    S_SCAN,
    S_SQ_GO,
    S_SQ_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_FINISH
  } state_t;

  // Operand selection of the shared modular multiplier.
  typedef enum logic [1:0] {
    MM_REDUCE,
    MM_SQUARE,
    MM_MULT
  } mm_sel_t;

  typedef struct packed {
    logic    load;
    logic    cfg_we;
    logic    mm_start;
    mm_sel_t mm_sel;
    logic    acc_first;
    logic    exp_shift;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_small;
    logic mm_done;
    logic exp_msb;
    logic exp_empty;
    logic started;
    logic inv_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/mpi_mulmod.sv =====
// ----------------------------------------------------------------------------
// mpi_mulmod
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of x per
// cycle from the most significant bit. Requires y < m.
// ----------------------------------------------------------------------------
module mpi_mulmod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mpi_pkg::MOD_W-1:0] x_in,
  input  logic [mpi_pkg::MOD_W-1:0] y_in,
  input  logic [mpi_pkg::MOD_W-1:0] modulus,
  output logic                      done,
  output logic [mpi_pkg::MOD_W-1:0] prod_nxt
);

  localparam int TW = mpi_pkg::MOD_W + 2;

  logic                         busy_r, busy_nxt;
  logic [mpi_pkg::MM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mpi_pkg::MOD_W-1:0]    x_r, x_nxt;
  logic [mpi_pkg::MOD_W-1:0]    y_r, y_nxt;
  logic [mpi_pkg::MOD_W-1:0]    acc_r, acc_nxt;
  logic [TW-1:0]                sum, sum_m1, sum_m2, m1, m2;

  // The running value stays below m, so 2*acc + y stays below 3m.
  always_comb begin
    m1     = {2'b00, modulus};
    m2     = {1'b0, modulus, 1'b0};
    sum    = {1'b0, acc_r, 1'b0} + (x_r[mpi_pkg::MOD_W-1] ? {2'b00, y_r} : '0);
    sum_m1 = sum - m1;
    sum_m2 = sum - m2;
    if (sum >= m2) begin
      prod_nxt = sum_m2[mpi_pkg::MOD_W-1:0];
    end else if (sum >= m1) begin
      prod_nxt = sum_m1[mpi_pkg::MOD_W-1:0];
    end else begin
      prod_nxt = sum[mpi_pkg::MOD_W-1:0];
    end
  end

  assign done = busy_r && (cnt_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mpi_pkg::MM_CNT_W'(mpi_pkg::MOD_W - 1);
      x_nxt    = x_in;
      y_nxt    = y_in;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = prod_nxt;
      x_nxt   = {x_r[mpi_pkg::MOD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// ===== hdl/mpi_datapath.sv =====
// ----------------------------------------------------------------------------
// mpi_datapath
// Modulus register, operand and exponent registers, accumulator, the shared
// modular multiplier and the output register.
// ----------------------------------------------------------------------------
module mpi_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mpi_pkg::cmd_t             cmd,
  output mpi_pkg::status_t          status,
  input  logic [mpi_pkg::MOD_W-1:0] cfg_modulus,
  input  logic                      in_opcode,
  input  logic [mpi_pkg::MOD_W-1:0] in_base_value,
  input  logic [mpi_pkg::EXP_W-1:0] in_exponent,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mpi_pkg::MOD_W-1:0] out_result
);

  logic [mpi_pkg::MOD_W-1:0]     mod_r, mod_nxt;
  logic                          op_r, op_nxt;
  logic [mpi_pkg::MOD_W-1:0]     base_r, base_nxt;
  logic [mpi_pkg::MOD_W-1:0]     acc_r, acc_nxt;
  logic [mpi_pkg::EXP_W-1:0]     exp_r, exp_nxt;
  logic [mpi_pkg::EXP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          started_r, started_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [mpi_pkg::MOD_W-1:0]     out_result_r, out_result_nxt;
  logic [mpi_pkg::MOD_W-1:0]     mod_m2;
  logic [mpi_pkg::MOD_W-1:0]     mm_x, mm_y, mm_prod;
  logic                          mm_done;
  logic                          force_zero;

  always_comb begin
    case (cmd.mm_sel)
      mpi_pkg::MM_REDUCE: begin
        mm_x = base_r;
        mm_y = mpi_pkg::MOD_W'(1);
      end
      mpi_pkg::MM_SQUARE: begin
        mm_x = acc_r;
        mm_y = acc_r;
      end
      mpi_pkg::MM_MULT: begin
        mm_x = acc_r;
        mm_y = base_r;
      end
      default: begin
        mm_x = acc_r;
        mm_y = acc_r;
      end
    endcase
  end

  mpi_mulmod u_mulmod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mm_start),
    .x_in     (mm_x),
    .y_in     (mm_y),
    .modulus  (mod_r),
    .done     (mm_done),
    .prod_nxt (mm_prod)
  );

  assign mod_m2 = mod_r - mpi_pkg::MOD_W'(2);

  always_comb begin
    status.mod_small = (mod_r[mpi_pkg::MOD_W-1:1] == '0);
    status.mm_done   = mm_done;
    status.exp_msb   = exp_r[mpi_pkg::EXP_W-1];
    status.exp_empty = (cnt_r == '0);
    status.started   = started_r;
    status.inv_zero  = (op_r == mpi_pkg::OP_INVERSE) && (base_r == '0);
    status.out_free  = !out_valid_r || !out_stall;
  end

  // A modulus below two or the inverse of zero both give a zero result.
  assign force_zero = status.mod_small || status.inv_zero;

  always_comb begin
    mod_nxt        = mod_r;
    op_nxt         = op_r;
    base_nxt       = base_r;
    acc_nxt        = acc_r;
    exp_nxt        = exp_r;
    cnt_nxt        = cnt_r;
    started_nxt    = started_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.cfg_we) begin
      mod_nxt = cfg_modulus;
    end

    if (cmd.load) begin
      op_nxt      = in_opcode;
      base_nxt    = in_base_value;
      acc_nxt     = mpi_pkg::MOD_W'(1);
      cnt_nxt     = mpi_pkg::EXP_CNT_W'(mpi_pkg::EXP_W);
      started_nxt = 1'b0;
      if (in_opcode == mpi_pkg::OP_INVERSE) begin
        exp_nxt = {{(mpi_pkg::EXP_W - mpi_pkg::MOD_W){1'b0}}, mod_m2};
      end else begin
        exp_nxt = in_exponent;
      end
    end

    if (cmd.exp_shift) begin
      exp_nxt = {exp_r[mpi_pkg::EXP_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end

    // First set exponent bit: 1 squared times the base is just the base.
    if (cmd.acc_first) begin
      acc_nxt     = base_r;
      started_nxt = 1'b1;
    end

    if (mm_done) begin
      if (cmd.mm_sel == mpi_pkg::MM_REDUCE) begin
        base_nxt = mm_prod;
      end else begin
        acc_nxt = mm_prod;
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = force_zero ? '0 : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= mpi_pkg::MOD_RESET;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
    op_r         <= op_nxt;
    base_r       <= base_nxt;
    acc_r        <= acc_nxt;
    exp_r        <= exp_nxt;
    cnt_r        <= cnt_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== hdl/mpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpi_ctrl
// Sequencer for one request: base reduction, exponent scan with squares and
// multiplies on the shared unit, and hand-off to the output register.
// ----------------------------------------------------------------------------
module mpi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  mpi_pkg::status_t status,
  output mpi_pkg::cmd_t    cmd
);

  mpi_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpi_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.mod_small ? mpi_pkg::S_FINISH : mpi_pkg::S_RED_GO;
        end
      end
      mpi_pkg::S_RED_GO:   state_nxt = mpi_pkg::S_RED_WAIT;
      mpi_pkg::S_RED_WAIT: begin
        if (status.mm_done) begin
          state_nxt = mpi_pkg::S_SCAN;
        end
      end
      mpi_pkg::S_SCAN: begin
        if (status.inv_zero || status.exp_empty) begin
          state_nxt = mpi_pkg::S_FINISH;
        end else if (status.started) begin
          state_nxt = mpi_pkg::S_SQ_GO;
        end
      end
      mpi_pkg::S_SQ_GO:   state_nxt = mpi_pkg::S_SQ_WAIT;
      mpi_pkg::S_SQ_WAIT: begin
        if (status.mm_done) begin
          state_nxt = status.exp_msb ? mpi_pkg::S_MUL_GO : mpi_pkg::S_SCAN;
        end
      end
      mpi_pkg::S_MUL_GO:   state_nxt = mpi_pkg::S_MUL_WAIT;
      mpi_pkg::S_MUL_WAIT: begin
        if (status.mm_done) begin
          state_nxt = mpi_pkg::S_SCAN;
        end
      end
      mpi_pkg::S_FINISH: begin
        if (status.out_free) begin
          state_nxt = mpi_pkg::S_IDLE;
        end
      end
      default: state_nxt = mpi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mm_sel = mpi_pkg::MM_SQUARE;
    case (state_r)
      mpi_pkg::S_IDLE: begin
        cmd.load   = in_valid;
        cmd.cfg_we = cfg_valid;
      end
      mpi_pkg::S_RED_GO: begin
        cmd.mm_sel   = mpi_pkg::MM_REDUCE;
        cmd.mm_start = 1'b1;
      end
      mpi_pkg::S_RED_WAIT: begin
        cmd.mm_sel = mpi_pkg::MM_REDUCE;
      end
      mpi_pkg::S_SCAN: begin
        // Leading zero bits leave the accumulator at one and are skipped.
        if (!status.inv_zero && !status.exp_empty && !status.started) begin
          cmd.exp_shift = 1'b1;
          cmd.acc_first = status.exp_msb;
        end
      end
      mpi_pkg::S_SQ_GO: begin
        cmd.mm_start = 1'b1;
      end
      mpi_pkg::S_SQ_WAIT: begin
        cmd.exp_shift = status.mm_done && !status.exp_msb;
      end
      mpi_pkg::S_MUL_GO: begin
        cmd.mm_sel   = mpi_pkg::MM_MULT;
        cmd.mm_start = 1'b1;
      end
      mpi_pkg::S_MUL_WAIT: begin
        cmd.mm_sel    = mpi_pkg::MM_MULT;
        cmd.exp_shift = status.mm_done;
      end
      mpi_pkg::S_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign in_stall  = (state_r != mpi_pkg::S_IDLE);
  assign cfg_ready = (state_r == mpi_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/modular_power_and_inverse.sv =====
// ----------------------------------------------------------------------------
// modular_power_and_inverse
// Computes base^exponent mod modulus (opcode 0) or the Fermat inverse
// base^(modulus-2) mod modulus (opcode 1), one request at a time.
// ----------------------------------------------------------------------------
// One request is processed at a time; in_stall is high from the cycle after
// acceptance until the result has been placed in the output register. All
// arithmetic runs on one bit-serial modular multiplier that does each product
// as a start plus 31 steps. The base is first reduced. Each of the 63
// exponent bits then passes through the scan state; each bit below the
// highest set one adds a square and, when set, a multiply. Once the scan
// finds the exponent exhausted, the finish state hands the result to the
// output register, and the block returns to idle to accept the next request.
// A modulus below two goes straight to the hand-off and gives 0, and an
// inverse of zero gives 0 straight after the base reduction. A stalled
// result holds off the hand-off of the next one. The modulus may be written
// whenever cfg_ready is high; a waiting result is not disturbed.
// ----------------------------------------------------------------------------
module modular_power_and_inverse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mpi_pkg::MOD_W-1:0] cfg_modulus,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [mpi_pkg::MOD_W-1:0] in_base_value,
  input  logic [mpi_pkg::EXP_W-1:0] in_exponent,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mpi_pkg::MOD_W-1:0] out_result
);

  mpi_pkg::cmd_t    cmd;
  mpi_pkg::status_t status;

  mpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mpi_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_modulus   (cfg_modulus),
    .in_opcode     (in_opcode),
    .in_base_value (in_base_value),
    .in_exponent   (in_exponent),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result)
  );

endmodule

// ===== hdl/mpi_checker.sv =====
// ----------------------------------------------------------------------------
// mpi_checker
// Port-level checks for the modular power and inverse block, bound to the
// top level.
// ----------------------------------------------------------------------------
module mpi_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [mpi_pkg::MOD_W-1:0] cfg_modulus,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mpi_pkg::MOD_W-1:0] out_result
);

  logic [mpi_pkg::MOD_W-1:0] mod_r, mod_nxt;

  // Shadow copy of the modulus, tracked from configuration beats.
  assign mod_nxt = (cfg_valid && cfg_ready) ? cfg_modulus : mod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mpi_pkg::MOD_RESET;
    end else begin
      mod_r <= mod_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("stalled result beat changed");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ((mod_r < 2) ? (out_result == '0) : (out_result < mod_r)))
    else $error("result not reduced by the modulus");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while a request is in progress");

  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a request in progress");

  a_no_cfg_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cfg_ready)
    else $error("configuration accepted while busy");

endmodule

bind modular_power_and_inverse mpi_checker u_mpi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .cfg_modulus (cfg_modulus),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_result  (out_result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the modular power and inverse block. A short
// table of directed requests exercises the extremes, the zero-exponent and
// inverse-of-zero rules, the tiny and degenerate moduli and a composite
// modulus. Several phases of random requests follow, each under its own
// modulus. Requests without a known result go through a square-and-multiply
// model here; each result beat is compared with the oldest prediction. Both
// channels idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int MOD_W = mpi_pkg::MOD_W;
  localparam int EXP_W = mpi_pkg::EXP_W;
  localparam logic [MOD_W-1:0] MOD_RESET = mpi_pkg::MOD_RESET;
  localparam logic OP_POWER   = mpi_pkg::OP_POWER;
  localparam logic OP_INVERSE = mpi_pkg::OP_INVERSE;

  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 10;
  localparam int PER_PHASE    = 53;
  localparam int SETTLE_TICKS = 40;
  localparam int TICK_LIMIT   = 20_000_000;
  localparam int PRINT_CAP    = 40;
  localparam logic [EXP_W-1:0] EXP_FULL = '1;
  localparam logic [MOD_W-1:0] MOD_MAX  = '1;

  typedef struct packed {
    logic             set_mod;
    logic [MOD_W-1:0] modulus;
    logic             opcode;
    logic [MOD_W-1:0] base;
    logic [EXP_W-1:0] expo;
    logic             known;
    logic [MOD_W-1:0] want;
  } stim_row_t;

  typedef struct packed {
    logic             opcode;
    logic [MOD_W-1:0] base;
    logic [EXP_W-1:0] expo;
    logic [MOD_W-1:0] want;
  } residue_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_modulus = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_opcode = OP_POWER;
  logic [MOD_W-1:0] in_base_value = '0;
  logic [EXP_W-1:0] in_exponent = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [MOD_W-1:0] out_result;

  residue_t         pending_residues[$];
  residue_t         oldest;
  logic [MOD_W-1:0] live_modulus = MOD_RESET;
  int               idle_pct = 0;
  int               stall_left = 0;
  int               ticks = 0;
  int               n_errors = 0;
  int               n_sent = 0;
  int               n_inverse = 0;
  int               n_full_exp = 0;
  int               n_checked = 0;
  int               n_moduli = 0;

  // Rows with set_mod set are preceded by a write of their modulus.
  stim_row_t dir_plan [0:N_DIRECTED-1] = '{
    '{1'b0, 31'd0,       OP_POWER,   31'd0,          63'd0,   1'b1, 31'd1},
    '{1'b0, 31'd0,       OP_POWER,   31'd2,          63'd10,  1'b1, 31'd1024},
    '{1'b0, 31'd0,       OP_POWER,   MOD_MAX,        63'd1,   1'b1, 31'd147483633},
    '{1'b0, 31'd0,       OP_POWER,   MOD_MAX,        EXP_FULL, 1'b0, 31'd0},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd0,          EXP_FULL, 1'b1, 31'd0},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd1,          EXP_FULL, 1'b1, 31'd1},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd1000000007, 63'd0,   1'b1, 31'd0},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd2,          63'd0,   1'b1, 31'd500000004},
    '{1'b0, 31'd0,       OP_POWER,   31'd1000000006, 63'd2,   1'b1, 31'd1},
    '{1'b1, 31'd2,       OP_INVERSE, 31'd1,          63'd0,   1'b1, 31'd1},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd0,          63'd0,   1'b1, 31'd0},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd3,          63'd0,   1'b1, 31'd1},
    '{1'b0, 31'd0,       OP_POWER,   31'd5,          EXP_FULL, 1'b1, 31'd1},
    '{1'b1, MOD_MAX,     OP_POWER,   MOD_MAX,        63'd5,   1'b1, 31'd0},
    '{1'b0, 31'd0,       OP_POWER,   31'h7FFFFFFE,   63'd2,   1'b1, 31'd1},
    '{1'b0, 31'd0,       OP_INVERSE, 31'h7FFFFFFE,   63'd0,   1'b1, 31'h7FFFFFFE},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd123456789,  63'h2A5A_5A5A_5A5A_5A5A, 1'b0, 31'd0},
    '{1'b1, 31'd1,       OP_POWER,   31'd5,          63'd0,   1'b1, 31'd0},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd7,          63'd0,   1'b1, 31'd0},
    '{1'b1, 31'd0,       OP_POWER,   MOD_MAX,        63'd3,   1'b1, 31'd0},
    '{1'b0, 31'd0,       OP_INVERSE, 31'd1,          63'd0,   1'b1, 31'd0},
    '{1'b1, 31'd1000000, OP_INVERSE, 31'd3,          63'd0,   1'b0, 31'd0},
    '{1'b0, 31'd0,       OP_POWER,   31'd10,         63'd6,   1'b1, 31'd0},
    '{1'b1, 31'd3,       OP_INVERSE, 31'd2,          63'd0,   1'b1, 31'd2},
    '{1'b0, 31'd0,       OP_POWER,   31'd2,          63'h1555_5555_5555_5555, 1'b0, 31'd0}
  };

  logic [MOD_W-1:0] phase_moduli [0:N_PHASES-1] = '{
    MOD_RESET, MOD_MAX, 31'd0, 31'd2, 31'd65537,
    31'd0, 31'd998244353, 31'd1, 31'd0, MOD_RESET
  };

  modular_power_and_inverse dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_modulus  (cfg_modulus),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_base_value(in_base_value),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Square-and-multiply over all exponent bits, most significant first.
  function automatic logic [MOD_W-1:0] modpow_predict(input logic opcode,
                                                      input logic [MOD_W-1:0] base,
                                                      input logic [EXP_W-1:0] expo,
                                                      input logic [MOD_W-1:0] m);
    logic [63:0] mm;
    logic [63:0] b;
    logic [63:0] acc;
    logic [EXP_W-1:0] e;
    if (m < 2) return '0;
    mm = 64'(m);
    b = 64'(base) % mm;
    e = expo;
    if (opcode == OP_INVERSE) begin
      if (b == 0) return '0;
      e = EXP_W'(mm - 64'd2);
    end
    acc = 64'd1;
    for (int i = EXP_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (e[i]) acc = (acc * b) % mm;
    end
    return acc[MOD_W-1:0];
  endfunction

  task automatic log_mismatch(input string what);
    n_errors++;
    if (n_errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high.
  task automatic send_request(input logic opcode, input logic [MOD_W-1:0] base,
                              input logic [EXP_W-1:0] expo, input logic known,
                              input logic [MOD_W-1:0] want);
    residue_t entry;
    int gap;
    gap = ($urandom_range(0, 99) < 2 * idle_pct) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= opcode;
    in_base_value <= base;
    in_exponent   <= expo;
    do @(posedge clk); while (in_stall);
    entry.opcode = opcode;
    entry.base   = base;
    entry.expo   = expo;
    entry.want   = known ? want : modpow_predict(opcode, base, expo, live_modulus);
    pending_residues = {pending_residues, entry};
    n_sent++;
    if (opcode == OP_INVERSE) n_inverse++;
    if (expo[EXP_W-1]) n_full_exp++;
    @(negedge clk);
  endtask

  // Called at a falling edge; the block is drained before the write.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_modulus <= value;
    do @(posedge clk); while (!cfg_ready);
    live_modulus = value;
    n_moduli++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side stalls in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_residues.size() == 0) begin
        log_mismatch($sformatf("result beat %0d arrived with no request outstanding",
                               out_result));
      end else begin
        oldest = pending_residues.pop_front();
        n_checked++;
        if (out_result !== oldest.want)
          log_mismatch($sformatf("op %0d base %0d exp 0x%0h mod %0d: got %0d, want %0d",
                                 oldest.opcode, oldest.base, oldest.expo, live_modulus,
                                 out_result, oldest.want));
      end
    end
  end

  always @(posedge clk) begin
    ticks <= ticks + 1;
    if (ticks == TICK_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               ticks, pending_residues.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t        row;
    logic             opcode;
    logic [MOD_W-1:0] base;
    logic [EXP_W-1:0] expo;
    logic [63:0]      raw;
    int               pick;
    int               w;

    phase_moduli[2] = 31'($urandom) | 31'h4000_0000;
    phase_moduli[5] = 31'($urandom_range(3, 1000));
    phase_moduli[8] = 31'($urandom_range(2, 32'h7FFF_FFFF));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 10;
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = dir_plan[r];
      if (row.set_mod) write_modulus(row.modulus);
      send_request(row.opcode, row.base, row.expo, row.known, row.want);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_modulus(phase_moduli[phase]);
      idle_pct = (phase == N_PHASES - 1) ? 0 : 5 * $urandom_range(0, 4);
      for (int k = 0; k < PER_PHASE; k++) begin
        opcode = ($urandom_range(0, 9) < 3) ? OP_INVERSE : OP_POWER;

        pick = $urandom_range(0, 9);
        case (pick)
          0:       base = '0;
          1:       base = MOD_MAX;
          2:       base = live_modulus - 31'($urandom_range(0, 2));
          3:       base = 31'($urandom_range(1, 20));
          default: base = 31'($urandom);
        endcase

        // Most exponents are short to keep the run brief; a few span all bits.
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          expo = EXP_FULL;
        end else if (pick < 8) begin
          expo = '0;
        end else begin
          if (pick < 63) w = $urandom_range(1, 12);
          else if (pick < 90) w = $urandom_range(13, 40);
          else w = $urandom_range(41, 63);
          expo = EXP_W'(raw & ((64'd1 << w) - 64'd1));
        end

        send_request(opcode, base, expo, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_residues.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Sent %0d requests (%0d inverses, %0d with bit 62 of the exponent set)",
             n_sent, n_inverse, n_full_exp);
    $display("under %0d modulus writes; %0d results compared, %0d mismatches",
             n_moduli, n_checked, n_errors);
    if (n_errors == 0 && pending_residues.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== modular_power_and_inverse.f =====
hdl/mpi_pkg.sv
hdl/mpi_mulmod.sv
hdl/mpi_datapath.sv
hdl/mpi_ctrl.sv
hdl/modular_power_and_inverse.sv
hdl/mpi_checker.sv
verif/tb.sv
